>>> hdl/mlt_pkg.sv
// mlt_pkg: shared types and constants for the MAC learning table with aging
// used by mlt_engine, mlt_out_reg and the top level; no dependencies
package mlt_pkg;

  localparam int MAC_W   = 48;
  localparam int PORT_W  = 4;
  localparam int STAMP_W = 16;
  localparam int AGE_W   = 12;
  localparam int CNT_W   = 9;
  localparam int OP_W    = 2;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int NUM_PORTS       = 16;
  localparam int PORT_LIM_W      = 9;

  localparam logic [AGE_W-1:0] MAX_AGE_RST = AGE_W'(30);
  localparam logic [CNT_W-1:0] CNT_SAT     = '1;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_TICK   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic               vld;
    logic [MAC_W-1:0]   mac;
    logic [PORT_W-1:0]  port;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic              hit;
    logic [PORT_W-1:0] found_port;
    logic [CNT_W-1:0]  removed_count;
    logic              status;
  } result_t;

endpackage

>>> hdl/mlt_ram.sv
// mlt_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module mlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/mlt_engine.sv
// mlt_engine: control fsm that walks the entry ram one entry per cycle
// for lookup, learn and aging sweep; depends on mlt_pkg and drives mlt_ram ports
module mlt_engine #(
  parameter int TABLE_DEPTH = mlt_pkg::TABLE_DEPTH_DEF,
  localparam int AW = $clog2(TABLE_DEPTH),
  localparam int EW = $bits(mlt_pkg::entry_t)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [mlt_pkg::AGE_W-1:0]  cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [mlt_pkg::OP_W-1:0]   in_opcode,
  input  logic [mlt_pkg::MAC_W-1:0]  in_mac_address,
  input  logic [mlt_pkg::PORT_W-1:0] in_port_number,
  output logic                       ram_wr_en,
  output logic [AW-1:0]              ram_wr_addr,
  output logic [EW-1:0]              ram_wr_data,
  output logic                       ram_rd_en,
  output logic [AW-1:0]              ram_rd_addr,
  input  logic [EW-1:0]              ram_rd_data,
  input  logic                       res_ready,
  output logic                       res_load,
  output mlt_pkg::result_t           res
);

  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);
  localparam logic [mlt_pkg::PORT_LIM_W-1:0] PORT_LIM =
    mlt_pkg::PORT_LIM_W'(mlt_pkg::NUM_PORTS);

  mlt_pkg::state_t state_r, state_nxt;
  mlt_pkg::op_t    op_r, op_nxt;
  logic [mlt_pkg::MAC_W-1:0]   mac_r, mac_nxt;
  logic [mlt_pkg::PORT_W-1:0]  port_r, port_nxt;
  logic [mlt_pkg::STAMP_W-1:0] time_r, time_nxt;
  logic [mlt_pkg::AGE_W-1:0]   max_age_r, max_age_nxt;
  logic [AW-1:0]               scan_idx_r, scan_idx_nxt;
  logic [AW-1:0]               free_idx_r, free_idx_nxt;
  logic                        free_found_r, free_found_nxt;
  mlt_pkg::result_t            res_r, res_nxt;

  mlt_pkg::entry_t rd_ent;
  mlt_pkg::entry_t wr_ent;
  logic accept, last, match, aged, port_ok, needs_scan;
  logic [mlt_pkg::STAMP_W-1:0] age;

  assign rd_ent  = mlt_pkg::entry_t'(ram_rd_data);
  assign accept  = in_valid && !in_stall;
  assign last    = (scan_idx_r == LAST_IDX);
  assign match   = rd_ent.vld && (rd_ent.mac == mac_r);
  assign age     = time_r - rd_ent.stamp;
  assign aged    = rd_ent.vld && (age > mlt_pkg::STAMP_W'(max_age_r));
  assign port_ok = (mlt_pkg::PORT_LIM_W'(in_port_number) < PORT_LIM);

  always_comb begin
    needs_scan = 1'b0;
    unique case (in_opcode)
      mlt_pkg::OP_LOOKUP: needs_scan = 1'b1;
      mlt_pkg::OP_INSERT: needs_scan = port_ok;
      mlt_pkg::OP_TICK:   needs_scan = 1'b1;
      default:            needs_scan = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mlt_pkg::ST_CLEAR: begin
        if (last) begin
          state_nxt = mlt_pkg::ST_IDLE;
        end
      end
      mlt_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = needs_scan ? mlt_pkg::ST_SCAN : mlt_pkg::ST_RESP;
        end
      end
      mlt_pkg::ST_SCAN: begin
        if (last || (match && op_r != mlt_pkg::OP_TICK)) begin
          state_nxt = mlt_pkg::ST_RESP;
        end
      end
      mlt_pkg::ST_RESP: begin
        if (res_ready) begin
          state_nxt = mlt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mlt_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_stall       = (state_r != mlt_pkg::ST_IDLE);
    res_load       = 1'b0;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = '0;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = scan_idx_r;
    wr_ent         = '0;
    op_nxt         = op_r;
    mac_nxt        = mac_r;
    port_nxt       = port_r;
    time_nxt       = time_r;
    max_age_nxt    = cfg_wr_en ? cfg_wr_data : max_age_r;
    scan_idx_nxt   = scan_idx_r;
    free_idx_nxt   = free_idx_r;
    free_found_nxt = free_found_r;
    res_nxt        = res_r;

    unique case (state_r)
      mlt_pkg::ST_CLEAR: begin
        ram_wr_en    = 1'b1;
        scan_idx_nxt = last ? '0 : scan_idx_r + AW'(1);
      end
      mlt_pkg::ST_IDLE: begin
        if (accept) begin
          op_nxt         = mlt_pkg::op_t'(in_opcode);
          mac_nxt        = in_mac_address;
          port_nxt       = in_port_number;
          res_nxt        = '0;
          free_found_nxt = 1'b0;
          scan_idx_nxt   = '0;
          ram_rd_en      = 1'b1;
          if (in_opcode == mlt_pkg::OP_TICK) begin
            time_nxt = time_r + mlt_pkg::STAMP_W'(1);
          end
        end
      end
      mlt_pkg::ST_SCAN: begin
        ram_rd_en    = !last;
        ram_rd_addr  = last ? '0 : scan_idx_r + AW'(1);
        scan_idx_nxt = last ? '0 : scan_idx_r + AW'(1);
        unique case (op_r)
          mlt_pkg::OP_LOOKUP: begin
            if (match) begin
              ram_wr_en          = 1'b1;
              wr_ent             = rd_ent;
              wr_ent.stamp       = time_r;
              res_nxt.hit        = 1'b1;
              res_nxt.found_port = rd_ent.port;
            end
          end
          mlt_pkg::OP_INSERT: begin
            wr_ent.vld   = 1'b1;
            wr_ent.mac   = mac_r;
            wr_ent.port  = port_r;
            wr_ent.stamp = time_r;
            if (match) begin
              ram_wr_en = 1'b1;
            end else if (last) begin
              if (free_found_r) begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = free_idx_r;
              end else if (!rd_ent.vld) begin
                ram_wr_en = 1'b1;
              end else begin
                res_nxt.status = 1'b1;
              end
            end else if (!rd_ent.vld && !free_found_r) begin
              free_idx_nxt   = scan_idx_r;
              free_found_nxt = 1'b1;
            end
          end
          default: begin
            // aging sweep
            if (aged) begin
              ram_wr_en = 1'b1;
              wr_ent    = rd_ent;
              wr_ent.vld = 1'b0;
              if (res_r.removed_count != mlt_pkg::CNT_SAT) begin
                res_nxt.removed_count = res_r.removed_count + mlt_pkg::CNT_W'(1);
              end
            end
          end
        endcase
      end
      mlt_pkg::ST_RESP: begin
        res_load = res_ready;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign ram_wr_data = EW'(wr_ent);
  assign res         = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mlt_pkg::ST_CLEAR;
      scan_idx_r   <= '0;
      free_found_r <= 1'b0;
      time_r       <= '0;
      max_age_r    <= mlt_pkg::MAX_AGE_RST;
    end else begin
      state_r      <= state_nxt;
      scan_idx_r   <= scan_idx_nxt;
      free_found_r <= free_found_nxt;
      time_r       <= time_nxt;
      max_age_r    <= max_age_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    mac_r      <= mac_nxt;
    port_r     <= port_nxt;
    free_idx_r <= free_idx_nxt;
    res_r      <= res_nxt;
  end

endmodule

>>> hdl/mlt_out_reg.sv
// mlt_out_reg: output holding register for the result word
// depends on mlt_pkg
module mlt_out_reg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  mlt_pkg::result_t           res,
  output logic                       ready,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_hit,
  output logic [mlt_pkg::PORT_W-1:0] out_found_port,
  output logic [mlt_pkg::CNT_W-1:0]  out_removed_count,
  output logic                       out_status
);

  logic             valid_r, valid_nxt;
  mlt_pkg::result_t data_r, data_nxt;

  assign ready = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r && out_stall;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid         = valid_r;
  assign out_hit           = data_r.hit;
  assign out_found_port    = data_r.found_port;
  assign out_removed_count = data_r.removed_count;
  assign out_status        = data_r.status;

endmodule

>>> hdl/mac_learning_table_with_aging.sv
// mac_learning_table_with_aging: top level of the MAC learning table
// depends on mlt_pkg, mlt_ram, mlt_engine and mlt_out_reg
//
// Fully associative MAC-to-port table held in one entry ram of TABLE_DEPTH
// words with a registered read. Every lookup, in-range learn and tick walks
// the ram one entry per cycle, so throughput is set by that single read port.
// A tick walks all TABLE_DEPTH entries; a lookup or a learn ends its walk at
// the first entry that holds its address, and otherwise walks them all. When
// the walk ends the result is handed to the output register, and the next
// word is accepted only after that. A learn with an out-of-range port or an
// unused opcode skips the walk. While out_stall holds back an earlier result,
// the finished result waits and in_stall stays high. After reset the ram is
// cleared, during which in_stall stays high; configuration writes are taken
// at any time.
module mac_learning_table_with_aging #(
  parameter int TABLE_DEPTH = mlt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [mlt_pkg::AGE_W-1:0]  cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [mlt_pkg::OP_W-1:0]   in_opcode,
  input  logic [mlt_pkg::MAC_W-1:0]  in_mac_address,
  input  logic [mlt_pkg::PORT_W-1:0] in_port_number,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_hit,
  output logic [mlt_pkg::PORT_W-1:0] out_found_port,
  output logic [mlt_pkg::CNT_W-1:0]  out_removed_count,
  output logic                       out_status
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int EW = $bits(mlt_pkg::entry_t);

  logic             ram_wr_en, ram_rd_en;
  logic [AW-1:0]    ram_wr_addr, ram_rd_addr;
  logic [EW-1:0]    ram_wr_data, ram_rd_data;
  logic             res_ready, res_load;
  mlt_pkg::result_t res;

  mlt_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  mlt_engine #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_mac_address (in_mac_address),
    .in_port_number (in_port_number),
    .ram_wr_en      (ram_wr_en),
    .ram_wr_addr    (ram_wr_addr),
    .ram_wr_data    (ram_wr_data),
    .ram_rd_en      (ram_rd_en),
    .ram_rd_addr    (ram_rd_addr),
    .ram_rd_data    (ram_rd_data),
    .res_ready      (res_ready),
    .res_load       (res_load),
    .res            (res)
  );

  mlt_out_reg u_out_reg (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (res_load),
    .res               (res),
    .ready             (res_ready),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_found_port    (out_found_port),
    .out_removed_count (out_removed_count),
    .out_status        (out_status)
  );

endmodule

>>> bench/mlt_checker.sv
// mlt_checker: keeps its own copy of the forwarding table, predicts the answer to every
// request word and compares it with the result word; depends on mlt_pkg only
`timescale 1ns / 1ps
module mlt_checker #(
  parameter int DEPTH = mlt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [mlt_pkg::AGE_W-1:0]  cfg_wr_data,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [mlt_pkg::OP_W-1:0]   in_opcode,
  input  logic [mlt_pkg::MAC_W-1:0]  in_mac_address,
  input  logic [mlt_pkg::PORT_W-1:0] in_port_number,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic                       out_hit,
  input  logic [mlt_pkg::PORT_W-1:0] out_found_port,
  input  logic [mlt_pkg::CNT_W-1:0]  out_removed_count,
  input  logic                       out_status,
  output int                         fail_count,
  output int                         pending
);

  logic                        fdb_valid [DEPTH];
  logic [mlt_pkg::MAC_W-1:0]   fdb_mac   [DEPTH];
  logic [mlt_pkg::PORT_W-1:0]  fdb_port  [DEPTH];
  logic [mlt_pkg::STAMP_W-1:0] fdb_stamp [DEPTH];
  logic [mlt_pkg::STAMP_W-1:0] sec_now;
  logic [mlt_pkg::AGE_W-1:0]   age_limit;
  mlt_pkg::result_t            answer_q [$];

  function automatic int find_mac(logic [mlt_pkg::MAC_W-1:0] mac);
    int i;
    for (i = 0; i < DEPTH; i++)
      if (fdb_valid[i] && fdb_mac[i] == mac) return i;
    return -1;
  endfunction

  function automatic mlt_pkg::result_t learn_and_age(logic [mlt_pkg::OP_W-1:0] op,
                                                     logic [mlt_pkg::MAC_W-1:0] mac,
                                                     logic [mlt_pkg::PORT_W-1:0] port);
    mlt_pkg::result_t            res;
    int                          slot;
    int                          i;
    logic [mlt_pkg::STAMP_W-1:0] age;
    res = '0;
    case (op)
      mlt_pkg::OP_LOOKUP: begin
        slot = find_mac(mac);
        if (slot >= 0) begin
          res.hit         = 1'b1;
          res.found_port  = fdb_port[slot];
          fdb_stamp[slot] = sec_now;
        end
      end
      mlt_pkg::OP_INSERT: begin
        if (int'(port) < mlt_pkg::NUM_PORTS) begin
          slot = find_mac(mac);
          for (i = 0; i < DEPTH && slot < 0; i++)
            if (!fdb_valid[i]) slot = i;
          if (slot >= 0) begin
            fdb_valid[slot] = 1'b1;
            fdb_mac[slot]   = mac;
            fdb_port[slot]  = port;
            fdb_stamp[slot] = sec_now;
          end else begin
            res.status = 1'b1;
          end
        end
      end
      mlt_pkg::OP_TICK: begin
        // counter moves first, then the sweep
        sec_now = sec_now + 1'b1;
        for (i = 0; i < DEPTH; i++) begin
          if (fdb_valid[i]) begin
            age = sec_now - fdb_stamp[i];
            if (age > age_limit) begin
              fdb_valid[i] = 1'b0;
              if (res.removed_count != mlt_pkg::CNT_SAT)
                res.removed_count = res.removed_count + 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic int field_bad(string field, int unsigned want, int unsigned got);
    if (want == got) return 0;
    $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    mlt_pkg::result_t got;
    mlt_pkg::result_t want;
    int               errs;
    int               i;
    errs = 0;
    if (!rst_n) begin
      for (i = 0; i < DEPTH; i++) fdb_valid[i] = 1'b0;
      sec_now   = '0;
      age_limit = mlt_pkg::MAX_AGE_RST;
      answer_q.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_hit, out_found_port, out_removed_count, out_status};
        if (answer_q.size() == 0) begin
          $display("%0t: result word expected none actual %h", $time, got);
          errs = 1;
        end else begin
          want = answer_q.pop_front();
          errs += field_bad("hit", want.hit, got.hit);
          errs += field_bad("found_port", want.found_port, got.found_port);
          errs += field_bad("removed_count", want.removed_count, got.removed_count);
          errs += field_bad("status", want.status, got.status);
        end
      end
      if (in_valid && !in_stall)
        answer_q.push_back(learn_and_age(in_opcode, in_mac_address, in_port_number));
      if (cfg_wr_en) age_limit = cfg_wr_data;
      fail_count <= fail_count + errs;
      pending    <= answer_q.size();
    end
  end

endmodule

>>> bench/mac_learning_table_with_aging_tb.sv
// mac_learning_table_with_aging_tb: drives request words, result stalls and max age
// writes into the learning table; checking is done by mlt_checker; uses mlt_pkg
`timescale 1ns / 1ps
module mac_learning_table_with_aging_tb;

  localparam logic [mlt_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_LIMIT   = 20000;
  localparam int HOLD_OFF     = 1500;
  localparam int DRAIN_CYCLES = 300;
  localparam int SEG_WORDS    = 80;
  localparam int FILL_WORDS   = mlt_pkg::TABLE_DEPTH_DEF + 6;
  localparam int SEG_AGE [7]  = '{30, 4095, 2, 0, 9, 1, 600};

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_wr_en;
  logic [mlt_pkg::AGE_W-1:0]  cfg_wr_data;
  logic                       in_valid;
  logic                       in_stall;
  logic [mlt_pkg::OP_W-1:0]   in_opcode;
  logic [mlt_pkg::MAC_W-1:0]  in_mac_address;
  logic [mlt_pkg::PORT_W-1:0] in_port_number;
  logic                       out_valid;
  logic                       out_stall;
  logic                       out_hit;
  logic [mlt_pkg::PORT_W-1:0] out_found_port;
  logic [mlt_pkg::CNT_W-1:0]  out_removed_count;
  logic                       out_status;

  int                        fail_count;
  int                        pending;
  int                        words_out    = 0;
  int                        quiet_cycles = 0;
  bit                        gaps_on      = 1'b1;
  bit                        long_hold_done = 1'b0;
  logic [mlt_pkg::MAC_W-1:0] mac_pool [16];

  mac_learning_table_with_aging u_top (.*);

  mlt_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (out_valid && !out_stall) words_out <= words_out + 1;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 200);
  endfunction

  function automatic logic [mlt_pkg::MAC_W-1:0] fresh_mac();
    return mlt_pkg::MAC_W'({$urandom, $urandom});
  endfunction

  function automatic logic [mlt_pkg::MAC_W-1:0] pick_mac();
    if ($urandom_range(0, 99) < 75) return mac_pool[$urandom_range(0, 15)];
    return fresh_mac();
  endfunction

  task automatic send_word(logic [mlt_pkg::OP_W-1:0] op, logic [mlt_pkg::MAC_W-1:0] mac,
                           logic [mlt_pkg::PORT_W-1:0] port);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_mac_address <= mac;
    in_port_number <= port;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_max_age(logic [mlt_pkg::AGE_W-1:0] age);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= age;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic random_segment(int seg);
    int                       r;
    logic [mlt_pkg::OP_W-1:0] op;
    wait_idle();
    write_max_age(seg == 4 ? mlt_pkg::AGE_W'($urandom_range(3, 60))
                           : mlt_pkg::AGE_W'(SEG_AGE[seg]));
    gaps_on = (seg != 2);
    repeat (SEG_WORDS) begin
      r  = $urandom_range(0, 99);
      op = r < 40 ? mlt_pkg::OP_LOOKUP :
           r < 75 ? mlt_pkg::OP_INSERT :
           r < 95 ? mlt_pkg::OP_TICK : OP_UNUSED;
      send_word(op, pick_mac(), mlt_pkg::PORT_W'($urandom));
    end
    gaps_on = 1'b1;
  endtask

  // receiver stalls, with one long hold-off once results are flowing
  initial begin
    int r;
    int hold;
    int run;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (!long_hold_done && words_out >= 40) begin
        long_hold_done = 1'b1;
        hold = HOLD_OFF;
        run  = 1;
      end else begin
        hold = r < 50 ? 0 : r < 90 ? $urandom_range(1, 4) : $urandom_range(20, 300);
        run  = r % 3 == 0 ? $urandom_range(50, 400) : $urandom_range(1, 20);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat (run) @(posedge clk);
    end
  end

  initial begin
    int i;
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    in_opcode      = mlt_pkg::OP_LOOKUP;
    in_mac_address = '0;
    in_port_number = '0;
    mac_pool[0] = '0;
    mac_pool[1] = '1;
    for (i = 2; i < 16; i++) mac_pool[i] = fresh_mac();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset max age, extremes of address and port
    send_word(mlt_pkg::OP_LOOKUP, '0, '0);
    send_word(OP_UNUSED, '1, 4'd15);
    send_word(mlt_pkg::OP_INSERT, '0, 4'd0);
    send_word(mlt_pkg::OP_INSERT, '1, 4'd15);
    send_word(mlt_pkg::OP_LOOKUP, '0, '1);
    send_word(mlt_pkg::OP_LOOKUP, '1, '0);
    send_word(mlt_pkg::OP_INSERT, '1, 4'd5);
    send_word(mlt_pkg::OP_LOOKUP, '1, '0);
    send_word(mlt_pkg::OP_TICK, '0, '0);
    send_word(mlt_pkg::OP_LOOKUP, 48'h5555_5555_5555, 4'd10);
    // zero max age drops anything a tick old
    wait_idle();
    write_max_age('0);
    send_word(mlt_pkg::OP_TICK, '0, '0);
    send_word(mlt_pkg::OP_LOOKUP, '0, '0);
    send_word(mlt_pkg::OP_INSERT, 48'hAAAA_AAAA_AAAA, 4'd10);
    send_word(mlt_pkg::OP_LOOKUP, 48'hAAAA_AAAA_AAAA, 4'd5);
    // lookup refreshes the stamp
    wait_idle();
    write_max_age(12'd1);
    send_word(mlt_pkg::OP_TICK, '0, '0);
    send_word(mlt_pkg::OP_LOOKUP, 48'hAAAA_AAAA_AAAA, '0);
    send_word(mlt_pkg::OP_TICK, '0, '0);
    send_word(mlt_pkg::OP_TICK, '0, '0);
    send_word(mlt_pkg::OP_LOOKUP, 48'hAAAA_AAAA_AAAA, '0);
    wait_idle();
    write_max_age('1);
    send_word(mlt_pkg::OP_INSERT, 48'h5555_5555_5555, 4'd3);
    send_word(mlt_pkg::OP_TICK, '1, '1);
    send_word(mlt_pkg::OP_LOOKUP, 48'h5555_5555_5555, '0);

    for (i = 0; i < 4; i++) random_segment(i);

    // fill the table past capacity, then age everything out in one sweep
    wait_idle();
    write_max_age('1);
    repeat (FILL_WORDS) send_word(mlt_pkg::OP_INSERT, fresh_mac(), mlt_pkg::PORT_W'($urandom));
    send_word(mlt_pkg::OP_INSERT, mac_pool[1], 4'd9);
    send_word(mlt_pkg::OP_LOOKUP, mac_pool[1], '0);
    wait_idle();
    write_max_age('0);
    send_word(mlt_pkg::OP_TICK, '0, '0);
    send_word(mlt_pkg::OP_TICK, '0, '0);
    send_word(mlt_pkg::OP_LOOKUP, mac_pool[1], '0);

    for (i = 4; i < 7; i++) random_segment(i);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
